// File: sv/epr_pkg.sv
// Shared types, constants and the arctangent table for the point rotation pipeline.
`timescale 1ns / 1ps

package epr_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CS_W         = 32;
  localparam int PHASE_W      = 32;
  localparam int FRAC_W       = 30;
  localparam int NUM_AXES     = 3;
  localparam int AXIS_X       = 0;
  localparam int AXIS_Y       = 1;
  localparam int AXIS_Z       = 2;
  localparam int SC_LAT       = CORDIC_STEPS + 2;
  localparam int ROT_LAT      = 2;

  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef struct packed {
    logic signed [CS_W-1:0] cos_v;
    logic signed [CS_W-1:0] sin_v;
  } sc_t;

  localparam int SC_W = $bits(sc_t);

  function automatic logic signed [CS_W-1:0] atan_turn(input int idx);
    case (idx)
      0:       return 32'sd536870912;
      1:       return 32'sd316933406;
      2:       return 32'sd167458907;
      3:       return 32'sd85004756;
      4:       return 32'sd42666307;
      5:       return 32'sd21354465;
      6:       return 32'sd10680862;
      7:       return 32'sd5340245;
      8:       return 32'sd2670163;
      9:       return 32'sd1335087;
      10:      return 32'sd667544;
      11:      return 32'sd333772;
      12:      return 32'sd166886;
      13:      return 32'sd83443;
      14:      return 32'sd41722;
      15:      return 32'sd20861;
      16:      return 32'sd10430;
      17:      return 32'sd5215;
      18:      return 32'sd2608;
      19:      return 32'sd1304;
      20:      return 32'sd652;
      21:      return 32'sd326;
      22:      return 32'sd163;
      23:      return 32'sd81;
      default: return '0;
    endcase
  endfunction

endpackage

// File: sv/epr_sincos.sv
// Pipelined three-lane CORDIC that turns the three angles into cosine and sine in Q1.30.
`timescale 1ns / 1ps

module epr_sincos #(
  parameter int AW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [AW-1:0]     in_angle [epr_pkg::NUM_AXES],
  output logic              out_vld,
  output epr_pkg::sc_t      out_sc [epr_pkg::NUM_AXES]
);
  import epr_pkg::*;

  localparam logic signed [PHASE_W-1:0] QUARTER     = 32'sh4000_0000;
  localparam logic signed [PHASE_W-1:0] NEG_QUARTER = 32'shC000_0000;

  logic signed [CS_W-1:0]    x_r   [NUM_AXES][CORDIC_STEPS+1];
  logic signed [CS_W-1:0]    y_r   [NUM_AXES][CORDIC_STEPS+1];
  logic signed [PHASE_W-1:0] z_r   [NUM_AXES][CORDIC_STEPS+1];
  logic                      neg_r [NUM_AXES][CORDIC_STEPS+1];
  logic                      vld_r [CORDIC_STEPS+1];
  logic                      out_vld_r;
  sc_t                       sc_r  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i <= CORDIC_STEPS; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_vld_r <= vld_r[CORDIC_STEPS];
    end
  end

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
    logic signed [PHASE_W-1:0] phase;
    logic                      fold;

    assign phase = {in_angle[k], {(PHASE_W-AW){1'b0}}};
    assign fold  = (phase > QUARTER) || (phase < NEG_QUARTER);

    always_ff @(posedge clk) begin
      x_r[k][0]   <= CORDIC_GAIN;
      y_r[k][0]   <= '0;
      z_r[k][0]   <= fold ? {~phase[PHASE_W-1], phase[PHASE_W-2:0]} : phase;
      neg_r[k][0] <= fold;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic signed [PHASE_W-1:0] ATAN = atan_turn(i);

      always_ff @(posedge clk) begin
        if (z_r[k][i] >= 0) begin
          x_r[k][i+1] <= x_r[k][i] - (y_r[k][i] >>> i);
          y_r[k][i+1] <= y_r[k][i] + (x_r[k][i] >>> i);
          z_r[k][i+1] <= z_r[k][i] - ATAN;
        end else begin
          x_r[k][i+1] <= x_r[k][i] + (y_r[k][i] >>> i);
          y_r[k][i+1] <= y_r[k][i] - (x_r[k][i] >>> i);
          z_r[k][i+1] <= z_r[k][i] + ATAN;
        end
        neg_r[k][i+1] <= neg_r[k][i];
      end
    end

    always_ff @(posedge clk) begin
      sc_r[k].cos_v <= neg_r[k][CORDIC_STEPS] ? -x_r[k][CORDIC_STEPS] : x_r[k][CORDIC_STEPS];
      sc_r[k].sin_v <= neg_r[k][CORDIC_STEPS] ? -y_r[k][CORDIC_STEPS] : y_r[k][CORDIC_STEPS];
    end

    assign out_sc[k] = sc_r[k];
  end

  assign out_vld = out_vld_r;

endmodule

// File: sv/epr_rot.sv
// Two-stage plane rotation: a*cos - b*sin and a*sin + b*cos, rounded from Q1.30.
`timescale 1ns / 1ps

module epr_rot #(
  parameter int DW     = 18,
  parameter int PASS_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [DW-1:0] in_a,
  input  logic signed [DW-1:0] in_b,
  input  epr_pkg::sc_t         in_sc,
  input  logic [PASS_W-1:0]    in_pass,
  output logic                 out_vld,
  output logic signed [DW-1:0] out_a,
  output logic signed [DW-1:0] out_b,
  output logic [PASS_W-1:0]    out_pass
);
  import epr_pkg::*;

  localparam int PW = DW + CS_W;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] RND = SW'(1) << (FRAC_W - 1);

  logic signed [PW-1:0] p_ac_r, p_bs_r, p_as_r, p_bc_r;
  logic [PASS_W-1:0]    pass1_r, pass2_r;
  logic                 vld1_r, vld2_r;
  logic signed [SW-1:0] sum_a, sum_b;
  logic signed [DW-1:0] a_r, b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_ac_r  <= in_a * $signed(in_sc.cos_v);
    p_bs_r  <= in_b * $signed(in_sc.sin_v);
    p_as_r  <= in_a * $signed(in_sc.sin_v);
    p_bc_r  <= in_b * $signed(in_sc.cos_v);
    pass1_r <= in_pass;
  end

  assign sum_a = SW'(p_ac_r) - SW'(p_bs_r) + RND;
  assign sum_b = SW'(p_as_r) + SW'(p_bc_r) + RND;

  always_ff @(posedge clk) begin
    a_r     <= sum_a[FRAC_W +: DW];
    b_r     <= sum_b[FRAC_W +: DW];
    pass2_r <= pass1_r;
  end

  assign out_vld  = vld2_r;
  assign out_a    = a_r;
  assign out_b    = b_r;
  assign out_pass = pass2_r;

endmodule

// File: sv/euler_point_rotation.sv
// Top level: rotates one 3D point about x, then y, then z, with saturated Q3.12 output.
//
// Usage:
//   Present a point (in_point_*) and three angles (in_angle_*) with start high.
//   The item is taken at a rising edge where start is high and busy is low;
//   busy is low whenever reset is released, so one item can be taken per cycle.
//   Each result appears on the out_* ports for exactly one cycle with out_valid
//   high, in the order the items came in.
//   Latency is set by the 24-step CORDIC pipeline (plus phase fold and sign
//   stages), three two-stage rotation units and the saturation register.
//   Throughput is one item per cycle.
//   Reset (rst_n low, synchronous) drops every item in flight and holds busy high.
//   The receiver cannot stall; results must be taken as they come.
//   out_saturated is high when any rotated coordinate was clamped to range.
`timescale 1ns / 1ps

module euler_point_rotation #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic [ANGLE_WIDTH-1:0]        in_angle_x,
  input  logic [ANGLE_WIDTH-1:0]        in_angle_y,
  input  logic [ANGLE_WIDTH-1:0]        in_angle_z,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_rotated_x,
  output logic signed [COORD_WIDTH-1:0] out_rotated_y,
  output logic signed [COORD_WIDTH-1:0] out_rotated_z,
  output logic                          out_saturated
);
  import epr_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int IW      = COORD_WIDTH + 2;
  localparam int OUT_LAT = SC_LAT + 3 * ROT_LAT + 1;
  localparam int P1_W    = IW + 2 * SC_W;
  localparam int P2_W    = IW + SC_W;
  localparam int P3_W    = IW;

  localparam logic signed [IW-1:0] C_MAX = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [IW-1:0] C_MIN = {3'b111, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] OUT_MAX = C_MAX[CW-1:0];
  localparam logic signed [CW-1:0] OUT_MIN = C_MIN[CW-1:0];

  logic                   accept;
  logic [ANGLE_WIDTH-1:0] angle [NUM_AXES];
  logic                   sc_vld;
  sc_t                    sc    [NUM_AXES];

  logic signed [CW-1:0]   px_d_r [SC_LAT];
  logic signed [CW-1:0]   py_d_r [SC_LAT];
  logic signed [CW-1:0]   pz_d_r [SC_LAT];

  logic signed [IW-1:0]   x0, y0, z0;
  logic                   r1_vld, r2_vld, r3_vld;
  logic signed [IW-1:0]   r1_y, r1_z, r1_x;
  logic signed [IW-1:0]   r2_z, r2_x, r2_y;
  logic signed [IW-1:0]   r3_x, r3_y, r3_z;
  sc_t                    r1_scy, r1_scz, r2_scz;
  logic [P1_W-1:0]        p1_out;
  logic [P2_W-1:0]        p2_out;

  logic                   sat_x, sat_y, sat_z;
  logic signed [CW-1:0]   rx_nxt, ry_nxt, rz_nxt;
  logic signed [CW-1:0]   rx_r, ry_r, rz_r;
  logic                   sat_r, out_valid_r;

  assign busy   = ~rst_n;
  assign accept = start && !busy;

  assign angle[AXIS_X] = in_angle_x;
  assign angle[AXIS_Y] = in_angle_y;
  assign angle[AXIS_Z] = in_angle_z;

  epr_sincos #(
    .AW (ANGLE_WIDTH)
  ) u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_angle (angle),
    .out_vld  (sc_vld),
    .out_sc   (sc)
  );

  always_ff @(posedge clk) begin
    px_d_r[0] <= in_point_x;
    py_d_r[0] <= in_point_y;
    pz_d_r[0] <= in_point_z;
    for (int i = 1; i < SC_LAT; i++) begin
      px_d_r[i] <= px_d_r[i-1];
      py_d_r[i] <= py_d_r[i-1];
      pz_d_r[i] <= pz_d_r[i-1];
    end
  end

  assign x0 = {{2{px_d_r[SC_LAT-1][CW-1]}}, px_d_r[SC_LAT-1]};
  assign y0 = {{2{py_d_r[SC_LAT-1][CW-1]}}, py_d_r[SC_LAT-1]};
  assign z0 = {{2{pz_d_r[SC_LAT-1][CW-1]}}, pz_d_r[SC_LAT-1]};

  // about x: y' = y*c - z*s, z' = y*s + z*c
  epr_rot #(
    .DW     (IW),
    .PASS_W (P1_W)
  ) u_rot_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sc_vld),
    .in_a     (y0),
    .in_b     (z0),
    .in_sc    (sc[AXIS_X]),
    .in_pass  ({x0, sc[AXIS_Y], sc[AXIS_Z]}),
    .out_vld  (r1_vld),
    .out_a    (r1_y),
    .out_b    (r1_z),
    .out_pass (p1_out)
  );

  assign {r1_x, r1_scy, r1_scz} = p1_out;

  // about y: z' = z*c - x*s, x' = z*s + x*c
  epr_rot #(
    .DW     (IW),
    .PASS_W (P2_W)
  ) u_rot_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (r1_vld),
    .in_a     (r1_z),
    .in_b     (r1_x),
    .in_sc    (r1_scy),
    .in_pass  ({r1_y, r1_scz}),
    .out_vld  (r2_vld),
    .out_a    (r2_z),
    .out_b    (r2_x),
    .out_pass (p2_out)
  );

  assign {r2_y, r2_scz} = p2_out;

  // about z: x' = x*c - y*s, y' = x*s + y*c
  epr_rot #(
    .DW     (IW),
    .PASS_W (P3_W)
  ) u_rot_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (r2_vld),
    .in_a     (r2_x),
    .in_b     (r2_y),
    .in_sc    (r2_scz),
    .in_pass  (r2_z),
    .out_vld  (r3_vld),
    .out_a    (r3_x),
    .out_b    (r3_y),
    .out_pass (r3_z)
  );

  always_comb begin
    sat_x  = (r3_x > C_MAX) || (r3_x < C_MIN);
    sat_y  = (r3_y > C_MAX) || (r3_y < C_MIN);
    sat_z  = (r3_z > C_MAX) || (r3_z < C_MIN);
    rx_nxt = sat_x ? (r3_x[IW-1] ? OUT_MIN : OUT_MAX) : r3_x[CW-1:0];
    ry_nxt = sat_y ? (r3_y[IW-1] ? OUT_MIN : OUT_MAX) : r3_y[CW-1:0];
    rz_nxt = sat_z ? (r3_z[IW-1] ? OUT_MIN : OUT_MAX) : r3_z[CW-1:0];
  end

  always_ff @(posedge clk) begin
    rx_r  <= rx_nxt;
    ry_r  <= ry_nxt;
    rz_r  <= rz_nxt;
    sat_r <= sat_x || sat_y || sat_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= r3_vld;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rotated_x = rx_r;
  assign out_rotated_y = ry_r;
  assign out_rotated_z = rz_r;
  assign out_saturated = sat_r;

`ifndef SYNTHESIS
  ap_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##OUT_LAT out_valid)
    else $error("item taken without a result at the fixed latency");

  ap_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, OUT_LAT))
    else $error("result without a matching item");

  ap_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_rotated_x == OUT_MAX || out_rotated_x == OUT_MIN ||
       out_rotated_y == OUT_MAX || out_rotated_y == OUT_MIN ||
       out_rotated_z == OUT_MAX || out_rotated_z == OUT_MIN))
    else $error("saturation flag set with no coordinate on a rail");

  ap_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");
`endif

endmodule

// File: test/euler_point_rotation_tb.sv
// Testbench for euler_point_rotation: random and corner points checked against a CORDIC predictor.
`timescale 1ns / 1ps

module euler_point_rotation_tb;

  localparam int COORD_W      = 16;
  localparam int ANGLE_W      = 16;
  localparam int RANDOM_ITEMS = 1430;
  localparam int CALM_ITEMS   = 200;
  localparam int SETTLE_CYC   = 45;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic [ANGLE_W-1:0]        ax;
    logic [ANGLE_W-1:0]        ay;
    logic [ANGLE_W-1:0]        az;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic signed [COORD_W-1:0] rz;
    logic                      sat;
  } rotated_t;

  class rotation_scoreboard;
    localparam longint GAIN_Q30 = 652032874;
    localparam longint HALF_Q30 = 536870912;
    localparam longint QUARTER  = 64'sd1 <<< 30;
    localparam longint HALF     = 64'sd1 <<< 31;
    localparam longint COORD_HI = 32767;
    localparam longint COORD_LO = -32768;

    longint   atan_steps[24];
    rotated_t rotated_q[$];
    int       mismatches;

    function new();
      atan_steps = '{536870912, 316933406, 167458907, 85004756, 42666307, 21354465,
                     10680862, 5340245, 2670163, 1335087, 667544, 333772,
                     166886, 83443, 41722, 20861, 10430, 5215,
                     2608, 1304, 652, 326, 163, 81};
      mismatches = 0;
    endfunction

    function void sin_cos(input logic [ANGLE_W-1:0] ang, output longint c, output longint s);
      logic [31:0] phase;
      longint      x;
      longint      y;
      longint      z;
      longint      xs;
      longint      ys;
      bit          flip;
      phase = {ang, {(32 - ANGLE_W){1'b0}}};
      z = $signed(phase);
      x = GAIN_Q30;
      y = 0;
      flip = 1'b0;
      // fold into the right half plane
      if (z > QUARTER) begin
        z = z - HALF;
        flip = 1'b1;
      end else if (z < -QUARTER) begin
        z = z + HALF;
        flip = 1'b1;
      end
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - atan_steps[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + atan_steps[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint round_q12(input longint v);
      return (v + HALF_Q30) >>> 30;
    endfunction

    function logic signed [COORD_W-1:0] clamp_coord(input longint v, inout bit clamped);
      if (v > COORD_HI) begin
        clamped = 1'b1;
        return COORD_HI[COORD_W-1:0];
      end
      if (v < COORD_LO) begin
        clamped = 1'b1;
        return COORD_LO[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
    endfunction

    function rotated_t rotate_point(input point_t p);
      longint   cx, sx, cy, sy, cz, sz;
      longint   x, y, z, t1, t2;
      bit       clamped;
      rotated_t r;
      sin_cos(p.ax, cx, sx);
      sin_cos(p.ay, cy, sy);
      sin_cos(p.az, cz, sz);
      x = $signed(p.px);
      y = $signed(p.py);
      z = $signed(p.pz);
      t1 = round_q12(y * cx - z * sx);
      t2 = round_q12(y * sx + z * cx);
      y = t1;
      z = t2;
      t1 = round_q12(z * sy + x * cy);
      t2 = round_q12(z * cy - x * sy);
      x = t1;
      z = t2;
      t1 = round_q12(x * cz - y * sz);
      t2 = round_q12(x * sz + y * cz);
      x = t1;
      y = t2;
      clamped = 1'b0;
      r.rx = clamp_coord(x, clamped);
      r.ry = clamp_coord(y, clamped);
      r.rz = clamp_coord(z, clamped);
      r.sat = clamped;
      return r;
    endfunction

    function void note_point(input point_t p);
      rotated_q.push_back(rotate_point(p));
    endfunction

    function void check_result(input rotated_t got);
      rotated_t want;
      if (rotated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: x=%0d y=%0d z=%0d sat=%0b",
                   got.rx, got.ry, got.rz, got.sat);
        return;
      end
      want = rotated_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                   want.rx, want.ry, want.rz, want.sat, got.rx, got.ry, got.rz, got.sat);
      end
    endfunction

    function int pending();
      return rotated_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;
  logic [ANGLE_W-1:0]        in_angle_x = '0;
  logic [ANGLE_W-1:0]        in_angle_y = '0;
  logic [ANGLE_W-1:0]        in_angle_z = '0;
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_rotated_x;
  logic signed [COORD_W-1:0] out_rotated_y;
  logic signed [COORD_W-1:0] out_rotated_z;
  logic                      out_saturated;

  rotation_scoreboard sb;
  int                 quiet_cycles = 0;

  euler_point_rotation #(
    .COORD_WIDTH(COORD_W),
    .ANGLE_WIDTH(ANGLE_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_point_z   (in_point_z),
    .in_angle_x   (in_angle_x),
    .in_angle_y   (in_angle_y),
    .in_angle_z   (in_angle_z),
    .out_valid    (out_valid),
    .out_rotated_x(out_rotated_x),
    .out_rotated_y(out_rotated_y),
    .out_rotated_z(out_rotated_z),
    .out_saturated(out_saturated)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_point('{in_point_x, in_point_y, in_point_z, in_angle_x, in_angle_y, in_angle_z});
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_rotated_x, out_rotated_y, out_rotated_z, out_saturated});
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic point_t make_point(input logic [15:0] x, y, z, ax, ay, az);
    return '{x, y, z, ax, ay, az};
  endfunction

  function automatic logic [ANGLE_W-1:0] near_fold_angle();
    return ANGLE_W'(($urandom_range(0, 3) << (ANGLE_W - 2)) + $urandom_range(0, 4) - 2);
  endfunction

  function automatic logic signed [COORD_W-1:0] corner_coord();
    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.px = COORD_W'($urandom);
    p.py = COORD_W'($urandom);
    p.pz = COORD_W'($urandom);
    p.ax = ANGLE_W'($urandom);
    p.ay = ANGLE_W'($urandom);
    p.az = ANGLE_W'($urandom);
    case ($urandom_range(0, 9))
      5: begin
        p.ax = near_fold_angle();
        p.ay = near_fold_angle();
        p.az = near_fold_angle();
      end
      6: begin
        p.px = corner_coord();
        p.py = corner_coord();
        p.pz = corner_coord();
      end
      7: begin
        case ($urandom_range(0, 2))
          0: {p.ay, p.az} = '0;
          1: {p.ax, p.az} = '0;
          default: {p.ax, p.ay} = '0;
        endcase
      end
      8: begin
        p.px = COORD_W'($urandom_range(0, 8191)) - 16'sd4096;
        p.py = COORD_W'($urandom_range(0, 8191)) - 16'sd4096;
        p.pz = COORD_W'($urandom_range(0, 8191)) - 16'sd4096;
      end
      default: ;
    endcase
    return p;
  endfunction

  // hold the item until the block takes it
  task automatic send_point(input point_t p);
    start      <= 1'b1;
    in_point_x <= p.px;
    in_point_y <= p.py;
    in_point_z <= p.pz;
    in_angle_x <= p.ax;
    in_angle_y <= p.ay;
    in_angle_z <= p.az;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    point_t directed[$];
    bit     gaps_on;
    sb = new();
    gaps_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_point(16'h7FFF, 16'h8000, 16'h1000, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_point(16'h1000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000));
    directed.push_back(make_point(16'h0000, 16'h1000, 16'h0000, 16'h4000, 16'h0000, 16'h0000));
    directed.push_back(make_point(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000));
    directed.push_back(make_point(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000));
    directed.push_back(make_point(16'h0000, 16'h1000, 16'h1000, 16'h8000, 16'h0000, 16'h0000));
    directed.push_back(make_point(16'h1000, 16'h1000, 16'h1000, 16'h4001, 16'hBFFF, 16'hC000));
    directed.push_back(make_point(16'h1000, 16'hF000, 16'h1000, 16'hC001, 16'h3FFF, 16'h7FFF));
    directed.push_back(make_point(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h0001));
    directed.push_back(make_point(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h2000));
    directed.push_back(make_point(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h2000));
    directed.push_back(make_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000, 16'h1800, 16'h2000));
    directed.push_back(make_point(16'h8000, 16'h7FFF, 16'h8000, 16'h6000, 16'hA000, 16'hE000));
    directed.push_back(make_point(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    directed.push_back(make_point(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    directed.push_back(make_point(16'h0001, 16'hFFFF, 16'h0001, 16'h8000, 16'h8000, 16'h8000));
    directed.push_back(make_point(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001));
    directed.push_back(make_point(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000));
    directed.push_back(make_point(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000));
    directed.push_back(make_point(16'h8000, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 16'h4000));
    directed.push_back(make_point(16'h0000, 16'h8000, 16'h7FFF, 16'hC000, 16'h8001, 16'h7FFF));

    foreach (directed[i]) begin
      send_point(directed[i]);
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 17));
    end
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_point(random_point());
      if (n < RANDOM_ITEMS - CALM_ITEMS && gaps_on && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 17));
    end

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
